@@ rtl/blr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, constants and types for the bidi line reorder core.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int CP_W  = 21;
    localparam int LVL_W = 7;
    localparam int CNT_W = 7;

    localparam logic [LVL_W-1:0] NO_ODD_LEVEL = 7'd126;

    typedef struct packed {
        logic             char_we;
        logic             lvl_we;
        logic [CNT_W-1:0] waddr;
        logic [CP_W-1:0]  char_wdata;
        logic [LVL_W-1:0] lvl_wdata;
        logic [CNT_W-1:0] char_raddr;
        logic [CNT_W-1:0] lvl_raddr;
    } blr_mem_req_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
        logic            ovf;
    } blr_result_t;

endpackage

@@ rtl/blr_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_line_store
// Character and level memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module blr_line_store
    import blr_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic             clk,
    input  blr_mem_req_t     req,
    output logic [CP_W-1:0]  char_rdata,
    output logic [LVL_W-1:0] lvl_rdata
);

    localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    logic [CP_W-1:0]  char_mem [0:LINE_CAPACITY-1];
    logic [LVL_W-1:0] lvl_mem  [0:LINE_CAPACITY-1];
    logic [CP_W-1:0]  char_rd_reg;
    logic [LVL_W-1:0] lvl_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.char_we)
        begin
            char_mem[req.waddr[ADDR_W-1:0]] <= req.char_wdata;
        end
        char_rd_reg <= char_mem[req.char_raddr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req.lvl_we)
        begin
            lvl_mem[req.waddr[ADDR_W-1:0]] <= req.lvl_wdata;
        end
        lvl_rd_reg <= lvl_mem[req.lvl_raddr[ADDR_W-1:0]];
    end

    assign char_rdata = char_rd_reg;
    assign lvl_rdata  = lvl_rd_reg;

endmodule

@@ rtl/blr_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_out_stage
// Result holding register on the output channel.
// ----------------------------------------------------------------------------
module blr_out_stage
    import blr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  blr_result_t     res,
    output logic            free,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [CP_W-1:0] out_codepoint,
    output logic            out_last,
    output logic            overflowed
);

    logic        valid_reg;
    logic        valid_next;
    blr_result_t res_reg;

    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_valid  = valid_reg;
    assign out_codepoint = res_reg.cp;
    assign out_last      = res_reg.last;
    assign overflowed    = res_reg.ovf;

endmodule

@@ rtl/blr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_ctrl
// Line loading, L2 run scan and swap sequencer, and visual-order readout.
// ----------------------------------------------------------------------------
module blr_ctrl
    import blr_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [CP_W-1:0]  codepoint,
    input  logic [LVL_W-1:0] embed_level,
    input  logic             last_in_line,
    output blr_mem_req_t     mem_req,
    input  logic [CP_W-1:0]  char_rdata,
    input  logic [LVL_W-1:0] lvl_rdata,
    input  logic             out_free,
    output logic             out_load,
    output blr_result_t      out_res
);

    typedef enum logic [9:0] {
        S_LOAD     = 10'b00_0000_0001,
        S_START    = 10'b00_0000_0010,
        S_SCAN_RD  = 10'b00_0000_0100,
        S_SCAN_CHK = 10'b00_0000_1000,
        S_SW_RDA   = 10'b00_0001_0000,
        S_SW_RDB   = 10'b00_0010_0000,
        S_SW_WRA   = 10'b00_0100_0000,
        S_SW_WRB   = 10'b00_1000_0000,
        S_EM_RD    = 10'b01_0000_0000,
        S_EM_WAIT  = 10'b10_0000_0000
    } state_t;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [LVL_W-1:0] high_reg,   high_next;
    logic [LVL_W-1:0] lowodd_reg, lowodd_next;
    logic             drop_reg,   drop_next;
    logic [LVL_W-1:0] lv_reg,     lv_next;
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] start_reg,  start_next;
    logic             in_run_reg, in_run_next;
    logic [CNT_W-1:0] lo_reg,     lo_next;
    logic [CNT_W-1:0] hi_reg,     hi_next;
    logic [CP_W-1:0]  swap_reg;

    logic accept;
    logic room;
    logic idx_last;

    assign item_stall = (state_reg != S_LOAD);
    assign accept     = item_valid && !item_stall;
    assign room       = (fill_reg < CAP);
    assign idx_last   = ((idx_reg + 7'd1) == fill_reg);

    always_comb
    begin
        mem_req.char_we    = 1'b0;
        mem_req.lvl_we     = 1'b0;
        mem_req.waddr      = fill_reg;
        mem_req.char_wdata = codepoint;
        mem_req.lvl_wdata  = embed_level;
        mem_req.lvl_raddr  = idx_reg;
        mem_req.char_raddr = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                mem_req.char_we = accept && room;
                mem_req.lvl_we  = accept && room;
            end
            S_SW_RDA:
            begin
                mem_req.char_raddr = lo_reg;
            end
            S_SW_RDB:
            begin
                mem_req.char_raddr = hi_reg;
            end
            S_SW_WRA:
            begin
                mem_req.char_we    = 1'b1;
                mem_req.waddr      = lo_reg;
                mem_req.char_wdata = char_rdata;
            end
            S_SW_WRB:
            begin
                mem_req.char_we    = 1'b1;
                mem_req.waddr      = hi_reg;
                mem_req.char_wdata = swap_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_load     = (state_reg == S_EM_WAIT) && out_free;
    assign out_res.cp   = char_rdata;
    assign out_res.last = idx_last;
    assign out_res.ovf  = drop_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        high_next   = high_reg;
        lowodd_next = lowodd_reg;
        drop_next   = drop_reg;
        lv_next     = lv_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        in_run_next = in_run_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + 7'd1;
                        if (embed_level > high_reg)
                        begin
                            high_next = embed_level;
                        end
                        if (embed_level[0] && (embed_level < lowodd_reg))
                        begin
                            lowodd_next = embed_level;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last_in_line)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                idx_next    = '0;
                in_run_next = 1'b0;
                lv_next     = high_reg;
                if (lowodd_reg == NO_ODD_LEVEL)
                begin
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    in_run_next = 1'b0;
                    if (in_run_reg && ((fill_reg - start_reg) >= 7'd2))
                    begin
                        lo_next    = start_reg;
                        hi_next    = fill_reg - 7'd1;
                        state_next = S_SW_RDA;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (lv_reg == lowodd_reg)
                        begin
                            state_next = S_EM_RD;
                        end
                        else
                        begin
                            lv_next = lv_reg - 7'd1;
                        end
                    end
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                idx_next   = idx_reg + 7'd1;
                state_next = S_SCAN_RD;
                if (lvl_rdata >= lv_reg)
                begin
                    if (!in_run_reg)
                    begin
                        start_next  = idx_reg;
                        in_run_next = 1'b1;
                    end
                end
                else
                begin
                    in_run_next = 1'b0;
                    if (in_run_reg && ((idx_reg - start_reg) >= 7'd2))
                    begin
                        lo_next    = start_reg;
                        hi_next    = idx_reg - 7'd1;
                        state_next = S_SW_RDA;
                    end
                end
            end
            S_SW_RDA:
            begin
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                state_next = S_SW_WRA;
            end
            S_SW_WRA:
            begin
                state_next = S_SW_WRB;
            end
            S_SW_WRB:
            begin
                lo_next = lo_reg + 7'd1;
                hi_next = hi_reg - 7'd1;
                if ((lo_reg + 7'd2) < hi_reg)
                begin
                    state_next = S_SW_RDA;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_EM_RD:
            begin
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + 7'd1;
                    if (idx_last)
                    begin
                        fill_next   = '0;
                        high_next   = '0;
                        lowodd_next = NO_ODD_LEVEL;
                        drop_next   = 1'b0;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            fill_reg   <= '0;
            high_reg   <= '0;
            lowodd_reg <= NO_ODD_LEVEL;
            drop_reg   <= 1'b0;
            lv_reg     <= '0;
            idx_reg    <= '0;
            start_reg  <= '0;
            in_run_reg <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            high_reg   <= high_next;
            lowodd_reg <= lowodd_next;
            drop_reg   <= drop_next;
            lv_reg     <= lv_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            in_run_reg <= in_run_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
        end
    end

    // left-hand character of the pair being swapped
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SW_RDB)
        begin
            swap_reg <= char_rdata;
        end
    end

endmodule

@@ rtl/bidi_line_reorder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidi_line_reorder_core
// Buffers one display line with its embedding levels, reverses level runs
// (highest level down to lowest odd level) in the line store, then streams
// the characters out in visual order.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   item     | item_valid / item_stall   | codepoint, embed_level, last_in_line
//   result   | result_valid/result_stall | out_codepoint, out_last, overflowed
//
// Loading: one character per cycle; items past LINE_CAPACITY are dropped.
// Reorder: set-up state S_START after the closing transfer; per level pass,
//   S_SCAN_RD and S_SCAN_CHK per stored character, S_SW_RDA/RDB/WRA/WRB per
//   swapped pair (single read port on the character memory). Readout: S_EM_RD,
//   then S_EM_WAIT until the output register is free, per character; item_stall
//   stays high from the closing transfer until the last result is in the output
//   register. Reset clears the line state only; the stores need no clearing.
// ----------------------------------------------------------------------------
module bidi_line_reorder_core
    import blr_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [CP_W-1:0]  codepoint,
    input  logic [LVL_W-1:0] embed_level,
    input  logic             last_in_line,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [CP_W-1:0]  out_codepoint,
    output logic             out_last,
    output logic             overflowed
);

    blr_mem_req_t     mem_req;
    logic [CP_W-1:0]  char_rdata;
    logic [LVL_W-1:0] lvl_rdata;
    logic             out_free;
    logic             out_load;
    blr_result_t      out_res;

    blr_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .codepoint    (codepoint),
        .embed_level  (embed_level),
        .last_in_line (last_in_line),
        .mem_req      (mem_req),
        .char_rdata   (char_rdata),
        .lvl_rdata    (lvl_rdata),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_res      (out_res)
    );

    blr_line_store #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_store (
        .clk        (clk),
        .req        (mem_req),
        .char_rdata (char_rdata),
        .lvl_rdata  (lvl_rdata)
    );

    blr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (out_res),
        .free          (out_free),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_codepoint (out_codepoint),
        .out_last      (out_last),
        .overflowed    (overflowed)
    );

endmodule

@@ rtl/blr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks for the bidi line reorder core.
// ----------------------------------------------------------------------------
module blr_checker
    import blr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  logic             last_in_line,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic [CP_W-1:0]  out_codepoint,
    input  logic             out_last,
    input  logic             overflowed
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(out_codepoint) && $stable(out_last) && $stable(overflowed))
        else $error("stalled result changed");

    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && last_in_line |=> item_stall)
        else $error("closing transfer did not start reorder");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_last |-> item_stall)
        else $error("input accepted while line still being emitted");

endmodule

bind bidi_line_reorder_core blr_checker u_blr_checker (.*);
